@@ rtl/mpem_pkg.sv @@
`default_nettype none

package mpem_pkg;

   // fixed field widths of the stream payloads
   localparam int OPCODE_W         = 2;
   localparam int PATTERN_INDEX_W  = 4;
   localparam int BYTE_OFFSET_W    = 6;
   localparam int BYTE_W           = 8;
   localparam int PATTERN_LENGTH_W = 7;
   localparam int MATCH_PATTERN_W  = 4;
   localparam int MATCH_START_W    = 32;

   // cap on result beats reported for one text byte
   localparam int MAX_RESULTS = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD_BYTE  = 2'd0,
      OP_SET_LENGTH = 2'd1,
      OP_TEXT_BYTE  = 2'd2,
      OP_NEW_TEXT   = 2'd3
   } mpem_opcode_type;

   typedef struct packed {
      mpem_opcode_type               opcode;
      logic [PATTERN_INDEX_W-1:0]    pattern_index;
      logic [BYTE_OFFSET_W-1:0]      byte_offset;
      logic [BYTE_W-1:0]             byte_value;
      logic [PATTERN_LENGTH_W-1:0]   pattern_length;
   } mpem_req_type;

   typedef struct packed {
      logic [MATCH_PATTERN_W-1:0]    match_pattern;
      logic [MATCH_START_W-1:0]      match_start;
      logic                          last_of_run;
   } mpem_rsp_type;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic advance;   // shift window, latch new prefix flags
      logic kill;      // drop all prefix flags
   } mpem_cell_ctrl_type;

   typedef enum logic {
      ST_RUN    = 1'b0,
      ST_REPLAY = 1'b1
   } mpem_state_type;

endpackage

`default_nettype wire

@@ rtl/mpem_stream_if.sv @@
`default_nettype none

interface mpem_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/mpem_cell.sv @@
`default_nettype none

// One byte column of the matcher: holds byte j of every pattern, one window
// byte, and the prefix flags "pattern p bytes 0..j match the text ending now".
module mpem_cell #(
   parameter int PATTERN_COUNT = 16,
   parameter int PIDX_W        = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mpem_pkg::mpem_cell_ctrl_type    ctrl,
   input  logic [mpem_pkg::BYTE_W-1:0]     feed_byte,
   input  logic [mpem_pkg::BYTE_W-1:0]     win_in,
   output logic [mpem_pkg::BYTE_W-1:0]     win_out,
   input  logic [PATTERN_COUNT-1:0]        prev_flags,
   output logic [PATTERN_COUNT-1:0]        flags_out,
   input  logic                            wr_en,
   input  logic [PIDX_W-1:0]               wr_index,
   input  logic [mpem_pkg::BYTE_W-1:0]     wr_byte,
   input  logic [PATTERN_COUNT-1:0]        end_sel,
   output logic [PATTERN_COUNT-1:0]        hit
);

   logic [mpem_pkg::BYTE_W-1:0] pat_ff [PATTERN_COUNT];
   logic [mpem_pkg::BYTE_W-1:0] win_ff;
   logic [PATTERN_COUNT-1:0]    flag_ff;
   logic [PATTERN_COUNT-1:0]    flag_in;

   always_comb begin
      for (int p = 0; p < PATTERN_COUNT; p++) begin
         flag_in[p] = prev_flags[p] & (pat_ff[p] == feed_byte);
      end
   end

   // pattern ends here when its length selects this column
   assign hit       = flag_in & end_sel;
   assign flags_out = flag_ff;
   assign win_out   = win_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.kill) begin
         flag_ff <= '0;
      end else if (ctrl.advance) begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_ff[wr_index] <= wr_byte;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mpem_emit.sv @@
`default_nettype none

// Match vector queue: a holding stage plus a draining stage that sends one
// beat per set bit, up to MAX_RESULTS, lowest pattern first.
module mpem_emit #(
   parameter int PATTERN_COUNT = 16,
   parameter int PIDX_W        = 4,
   parameter int LEN_W         = 7,
   parameter int POSITION_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [PATTERN_COUNT-1:0]  push_hit,
   input  logic [POSITION_BITS-1:0]  push_pos,
   input  logic [LEN_W-1:0]          push_len [PATTERN_COUNT],
   output logic                      space,
   mpem_stream_if.source             rsp_chan
);

   localparam int RES_W   = $clog2(mpem_pkg::MAX_RESULTS);
   localparam int DIFF_W  = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
   localparam int START_W = mpem_pkg::MATCH_START_W;
   localparam int MPAT_W  = mpem_pkg::MATCH_PATTERN_W;

   logic                     s1_valid_ff;
   logic [PATTERN_COUNT-1:0] s1_hit_ff;
   logic [POSITION_BITS-1:0] s1_pos_ff;
   logic [LEN_W-1:0]         s1_len_ff [PATTERN_COUNT];

   logic                     dr_valid_ff;
   logic [PATTERN_COUNT-1:0] dr_hit_ff;
   logic [POSITION_BITS-1:0] dr_pos_ff;
   logic [LEN_W-1:0]         dr_len_ff [PATTERN_COUNT];
   logic [RES_W-1:0]         dr_cnt_ff;

   logic [PIDX_W-1:0]        idx;
   logic [PATTERN_COUNT-1:0] rest;
   logic                     is_last;
   logic [DIFF_W-1:0]        start;
   logic                     beat;
   logic                     done;
   logic                     s1_move;

   always_comb begin
      idx = '0;
      for (int i = PATTERN_COUNT - 1; i >= 0; i--) begin
         if (dr_hit_ff[i]) begin
            idx = PIDX_W'(i);
         end
      end
   end

   always_comb begin
      rest      = dr_hit_ff;
      rest[idx] = 1'b0;
   end

   assign is_last = (rest == '0) || (dr_cnt_ff == RES_W'(mpem_pkg::MAX_RESULTS - 1));
   assign start   = DIFF_W'(dr_pos_ff) - DIFF_W'(dr_len_ff[idx]) + DIFF_W'(1);

   assign beat    = dr_valid_ff && rsp_chan.ready;
   assign done    = beat && is_last;
   assign s1_move = s1_valid_ff && (!dr_valid_ff || done);
   assign space   = !s1_valid_ff || s1_move;

   assign rsp_chan.valid              = dr_valid_ff;
   assign rsp_chan.data.match_pattern = MPAT_W'(idx);
   assign rsp_chan.data.match_start   = START_W'(start);
   assign rsp_chan.data.last_of_run   = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (push) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_hit_ff <= push_hit;
         s1_pos_ff <= push_pos;
         s1_len_ff <= push_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dr_valid_ff <= 1'b0;
      end else if (s1_move) begin
         dr_valid_ff <= 1'b1;
      end else if (done) begin
         dr_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         dr_hit_ff <= s1_hit_ff;
         dr_pos_ff <= s1_pos_ff;
         dr_len_ff <= s1_len_ff;
         dr_cnt_ff <= '0;
      end else if (beat && !is_last) begin
         dr_hit_ff <= rest;
         dr_cnt_ff <= dr_cnt_ff + RES_W'(1);
      end
   end

endmodule

`default_nettype wire

@@ rtl/multi_pattern_exact_matcher_unit.sv @@
`default_nettype none

// Multi-pattern exact matcher. Patterns are loaded byte by byte (opcode 0)
// and enabled by a length (opcode 1, zero disables); text then streams one
// byte per beat (opcode 2) and opcode 3 starts a new text. Matching runs in a
// chain of MAX_PATTERN_LENGTH byte cells: cell j keeps byte j of every
// pattern and a flag per pattern telling that bytes 0..j match the text
// ending at the newest byte; the flags walk one cell per text byte. The
// request side sustains one beat per clock while the match queue has
// space and no rebuild runs. A text byte that ends k patterns gives k
// response beats on consecutive cycles while the receiver is ready,
// lowest pattern index first; a two-deep match queue lets new bytes in
// while responses stall. Loading a pattern byte at an offset below the
// number of text bytes already seen rebuilds the flags by rotating the
// stored window once through the chain with the request side held off.
// No clearing pass follows reset. match_start is the low 32 bits of the
// saturating position of the last matched byte, less the length, plus 1.
module multi_pattern_exact_matcher_unit #(
   parameter int PATTERN_COUNT      = 16,
   parameter int MAX_PATTERN_LENGTH = 64,
   parameter int POSITION_BITS      = 32
) (
   input  logic           clock,
   input  logic           reset,
   mpem_stream_if.sink    req_chan,
   mpem_stream_if.source  rsp_chan
);

   localparam int PIDX_W = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN_LENGTH + 1);
   localparam int REP_W  = $clog2(MAX_PATTERN_LENGTH);
   localparam int BYTE_W = mpem_pkg::BYTE_W;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   mpem_pkg::mpem_state_type      st_ff;
   mpem_pkg::mpem_state_type      st_in;
   logic [REP_W-1:0]              rep_ff;
   logic [LEN_W-1:0]              txt_cnt_ff;
   logic [POSITION_BITS-1:0]      pos_ff;
   logic [LEN_W-1:0]              len_ff [PATTERN_COUNT];

   logic                          in_ready;
   logic                          accept;
   logic                          is_load;
   logic                          is_len;
   logic                          is_text;
   logic                          is_new;
   logic                          wr_ok;
   logic                          len_ok;
   logic                          needs_rebuild;
   logic                          rep_done;
   logic                          rep_live;
   logic [LEN_W-1:0]              len_new;
   logic                          emit_space;

   mpem_pkg::mpem_cell_ctrl_type  ctrl;
   logic [BYTE_W-1:0]             feed_byte;
   logic [BYTE_W-1:0]             win [MAX_PATTERN_LENGTH];
   logic [PATTERN_COUNT-1:0]      flags [MAX_PATTERN_LENGTH];
   logic [PATTERN_COUNT-1:0]      hit_col [MAX_PATTERN_LENGTH];
   logic [PATTERN_COUNT-1:0]      hit_all;

   assign req_chan.ready = in_ready;
   assign accept         = req_chan.valid && in_ready;

   always_comb begin
      is_load = 1'b0;
      is_len  = 1'b0;
      is_text = 1'b0;
      is_new  = 1'b0;
      unique case (req_chan.data.opcode)
         mpem_pkg::OP_LOAD_BYTE:  is_load = accept;
         mpem_pkg::OP_SET_LENGTH: is_len  = accept;
         mpem_pkg::OP_TEXT_BYTE:  is_text = accept;
         mpem_pkg::OP_NEW_TEXT:   is_new  = accept;
         default: begin
         end
      endcase
   end

   assign wr_ok  = is_load && (32'(req_chan.data.pattern_index) < PATTERN_COUNT)
                   && (32'(req_chan.data.byte_offset) < MAX_PATTERN_LENGTH);
   assign len_ok = is_len && (32'(req_chan.data.pattern_index) < PATTERN_COUNT);

   // a write below the seen text length invalidates flags already built
   assign needs_rebuild = wr_ok && (32'(req_chan.data.byte_offset) < 32'(txt_cnt_ff));
   assign rep_done      = (rep_ff == REP_W'(MAX_PATTERN_LENGTH - 1));
   // rotation feeds oldest byte first; only the last txt_cnt bytes are text
   assign rep_live      = (32'(rep_ff) + 32'(txt_cnt_ff)) >= MAX_PATTERN_LENGTH;

   always_comb begin
      if (32'(req_chan.data.pattern_length) > MAX_PATTERN_LENGTH) begin
         len_new = LEN_W'(MAX_PATTERN_LENGTH);
      end else begin
         len_new = LEN_W'(req_chan.data.pattern_length);
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         mpem_pkg::ST_RUN: begin
            if (needs_rebuild) begin
               st_in = mpem_pkg::ST_REPLAY;
            end
         end
         mpem_pkg::ST_REPLAY: begin
            if (rep_done) begin
               st_in = mpem_pkg::ST_RUN;
            end
         end
         default: st_in = mpem_pkg::ST_RUN;
      endcase
   end

   always_comb begin
      in_ready     = 1'b0;
      ctrl.advance = 1'b0;
      ctrl.kill    = 1'b0;
      feed_byte    = req_chan.data.byte_value;
      unique case (st_ff)
         mpem_pkg::ST_RUN: begin
            in_ready     = emit_space;
            ctrl.advance = is_text;
            ctrl.kill    = is_new;
         end
         mpem_pkg::ST_REPLAY: begin
            ctrl.advance = 1'b1;
            ctrl.kill    = !rep_live;
            feed_byte    = win[MAX_PATTERN_LENGTH-1];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mpem_pkg::ST_RUN;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || st_ff == mpem_pkg::ST_RUN) begin
         rep_ff <= '0;
      end else begin
         rep_ff <= rep_ff + REP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || is_new) begin
         txt_cnt_ff <= '0;
         pos_ff     <= '0;
      end else if (is_text) begin
         if (32'(txt_cnt_ff) < MAX_PATTERN_LENGTH) begin
            txt_cnt_ff <= txt_cnt_ff + LEN_W'(1);
         end
         if (pos_ff != POS_MAX) begin
            pos_ff <= pos_ff + POSITION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PATTERN_COUNT; p++) begin
            len_ff[p] <= '0;
         end
      end else if (len_ok) begin
         len_ff[PIDX_W'(req_chan.data.pattern_index)] <= len_new;
      end
   end

   for (genvar j = 0; j < MAX_PATTERN_LENGTH; j++) begin : g_cell
      logic [PATTERN_COUNT-1:0] end_sel;
      logic [PATTERN_COUNT-1:0] prev_flags;
      logic [BYTE_W-1:0]        win_in;
      logic                     wr_en;

      always_comb begin
         for (int p = 0; p < PATTERN_COUNT; p++) begin
            end_sel[p] = (len_ff[p] == LEN_W'(j + 1));
         end
      end

      if (j == 0) begin : g_head
         assign prev_flags = '1;
         assign win_in     = feed_byte;
      end else begin : g_link
         assign prev_flags = flags[j-1];
         assign win_in     = win[j-1];
      end

      assign wr_en = wr_ok && (32'(req_chan.data.byte_offset) == j);

      mpem_cell #(
         .PATTERN_COUNT (PATTERN_COUNT),
         .PIDX_W        (PIDX_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .feed_byte  (feed_byte),
         .win_in     (win_in),
         .win_out    (win[j]),
         .prev_flags (prev_flags),
         .flags_out  (flags[j]),
         .wr_en      (wr_en),
         .wr_index   (PIDX_W'(req_chan.data.pattern_index)),
         .wr_byte    (req_chan.data.byte_value),
         .end_sel    (end_sel),
         .hit        (hit_col[j])
      );
   end

   always_comb begin
      hit_all = '0;
      for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
         hit_all = hit_all | hit_col[j];
      end
   end

   mpem_emit #(
      .PATTERN_COUNT (PATTERN_COUNT),
      .PIDX_W        (PIDX_W),
      .LEN_W         (LEN_W),
      .POSITION_BITS (POSITION_BITS)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .push     (is_text && (|hit_all)),
      .push_hit (hit_all),
      .push_pos (pos_ff),
      .push_len (len_ff),
      .space    (emit_space),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(txt_cnt_ff) <= MAX_PATTERN_LENGTH)
      else $error("text byte count past window depth");

   a_rebuild_starts: assert property (@(posedge clock) disable iff (reset)
      needs_rebuild |=> (st_ff == mpem_pkg::ST_REPLAY))
      else $error("pattern write over live text did not start a rebuild");

   for (genvar j = 0; j < MAX_PATTERN_LENGTH; j++) begin : g_flag_chk
      a_flag_depth: assert property (@(posedge clock) disable iff (reset)
         (|flags[j]) |-> (32'(txt_cnt_ff) > j))
         else $error("prefix flag set deeper than text seen");
   end
`endif

endmodule

`default_nettype wire

@@ dv/multi_pattern_exact_matcher_unit_test.sv @@
class match_scoreboard #(int PATTERNS = 16, int WINDOW = 64);
   logic [7:0]             pat_mem [PATTERNS][WINDOW];
   bit                     written [PATTERNS][WINDOW];
   int unsigned            pat_len [PATTERNS];
   logic [7:0]             text_win [WINDOW];   // [0] is the newest text byte
   logic [31:0]            text_pos;
   mpem_pkg::mpem_rsp_type expected_matches [$];
   int unsigned            requests, text_bytes, checked, errors, widest_run;

   function new();
      foreach (pat_mem[p, k]) begin
         pat_mem[p][k] = '0;
         written[p][k] = 1'b0;
      end
      foreach (pat_len[p]) pat_len[p] = 0;
      foreach (text_win[k]) text_win[k] = '0;
      text_pos = '0;
   endfunction

   function int unsigned written_prefix(int unsigned p);
      int unsigned n;
      n = 0;
      while (n < WINDOW && written[p][n]) n++;
      return n;
   endfunction

   function void note_request(mpem_pkg::mpem_req_type r);
      logic [PATTERNS-1:0]    hit;
      int                     hits, last;
      bit                     same;
      mpem_pkg::mpem_rsp_type beat;
      requests++;
      case (r.opcode)
         mpem_pkg::OP_LOAD_BYTE: begin
            if (r.pattern_index < PATTERNS && r.byte_offset < WINDOW) begin
               pat_mem[r.pattern_index][r.byte_offset] = r.byte_value;
               written[r.pattern_index][r.byte_offset] = 1'b1;
            end
         end
         mpem_pkg::OP_SET_LENGTH: begin
            if (r.pattern_index < PATTERNS)
               pat_len[r.pattern_index] = (r.pattern_length > WINDOW) ? WINDOW : r.pattern_length;
         end
         mpem_pkg::OP_NEW_TEXT: begin
            foreach (text_win[k]) text_win[k] = '0;
            text_pos = '0;
         end
         default: begin
            text_bytes++;
            for (int k = WINDOW - 1; k > 0; k--) text_win[k] = text_win[k-1];
            text_win[0] = r.byte_value;
            hit = '0;
            hits = 0;
            last = 0;
            for (int p = 0; p < PATTERNS; p++) begin
               if (pat_len[p] == 0 || text_pos < pat_len[p] - 1 || hits == mpem_pkg::MAX_RESULTS)
                  continue;
               same = 1'b1;
               for (int k = 0; k < pat_len[p]; k++)
                  if (pat_mem[p][k] != text_win[pat_len[p] - 1 - k]) same = 1'b0;
               if (same) begin
                  hit[p] = 1'b1;
                  last = p;
                  hits++;
               end
            end
            for (int p = 0; p < PATTERNS; p++) begin
               if (!hit[p]) continue;
               beat.match_pattern = 4'(p);
               beat.match_start   = text_pos - (pat_len[p] - 1);
               beat.last_of_run   = (p == last);
               expected_matches = {expected_matches, beat};
            end
            if (hits > widest_run) widest_run = hits;
            // position saturation would take 2^32 text bytes; unreachable here
            if (text_pos != '1) text_pos++;
         end
      endcase
   endfunction

   function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $error("%s: expected %0h, got %0h", field, want, got);
   endfunction

   function void check_match(mpem_pkg::mpem_rsp_type got);
      mpem_pkg::mpem_rsp_type want;
      if (expected_matches.size() == 0) begin
         errors++;
         $error("match beat with none expected: pattern %0d, start %0h",
                got.match_pattern, got.match_start);
         return;
      end
      want = expected_matches.pop_front();
      checked++;
      if (got.match_pattern !== want.match_pattern)
         flag("match_pattern", want.match_pattern, got.match_pattern);
      if (got.match_start !== want.match_start)
         flag("match_start", want.match_start, got.match_start);
      if (got.last_of_run !== want.last_of_run)
         flag("last_of_run", want.last_of_run, got.last_of_run);
   endfunction
endclass

module multi_pattern_exact_matcher_unit_test;
   localparam int PATTERN_COUNT      = 16;
   localparam int MAX_PATTERN_LENGTH = 64;
   localparam int ITEM_TARGET        = 460;
   localparam int LONG_HOLD          = 300;
   localparam int QUIET_LIMIT        = 3000;
   localparam int TAIL_CYCLES        = 100;

   typedef match_scoreboard #(PATTERN_COUNT, MAX_PATTERN_LENGTH) scoreboard_type;

   logic clock = 1'b0;
   logic reset;
   int   burst_left = 0;
   bit   long_stall_wanted = 1'b0;

   scoreboard_type match_sb = new();

   mpem_stream_if #(.payload_type(mpem_pkg::mpem_req_type)) req_chan ();
   mpem_stream_if #(.payload_type(mpem_pkg::mpem_rsp_type)) rsp_chan ();

   multi_pattern_exact_matcher_unit #(
      .PATTERN_COUNT      (PATTERN_COUNT),
      .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
      .POSITION_BITS      (32)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // mostly a small alphabet so that short patterns hit often
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 4) == 0) return 8'($urandom);
      return 8'("a" + $urandom_range(0, 2));
   endfunction

   task automatic push_req(mpem_pkg::mpem_req_type r);
      int                                          gap;
      logic [$bits(mpem_pkg::mpem_req_type)-1:0]   junk;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            junk = $bits(mpem_pkg::mpem_req_type)'($urandom);
            @(negedge clock);
            req_chan.valid <= 1'b0;
            req_chan.data  <= junk;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.data  <= r;
      do @(posedge clock); while (!req_chan.ready);
      match_sb.note_request(r);
   endtask

   task automatic send_load(int unsigned p, int unsigned off, int unsigned val);
      mpem_pkg::mpem_req_type r;
      r = $bits(mpem_pkg::mpem_req_type)'($urandom);
      r.opcode        = mpem_pkg::OP_LOAD_BYTE;
      r.pattern_index = 4'(p);
      r.byte_offset   = 6'(off);
      r.byte_value    = 8'(val);
      push_req(r);
   endtask

   task automatic send_length(int unsigned p, int unsigned len);
      mpem_pkg::mpem_req_type r;
      r = $bits(mpem_pkg::mpem_req_type)'($urandom);
      r.opcode         = mpem_pkg::OP_SET_LENGTH;
      r.pattern_index  = 4'(p);
      r.pattern_length = 7'(len);
      push_req(r);
   endtask

   task automatic send_text(logic [7:0] val);
      mpem_pkg::mpem_req_type r;
      r = $bits(mpem_pkg::mpem_req_type)'($urandom);
      r.opcode     = mpem_pkg::OP_TEXT_BYTE;
      r.byte_value = val;
      push_req(r);
   endtask

   task automatic send_new_text();
      mpem_pkg::mpem_req_type r;
      r = $bits(mpem_pkg::mpem_req_type)'($urandom);
      r.opcode = mpem_pkg::OP_NEW_TEXT;
      push_req(r);
   endtask

   // loads bytes 0..len-1, then enables; now and then the length is never set
   task automatic program_pattern(int unsigned p, int unsigned len);
      bit backwards;
      backwards = $urandom_range(0, 1);
      for (int k = 0; k < len; k++)
         send_load(p, backwards ? len - 1 - k : k, pick_byte());
      if ($urandom_range(0, 7) == 0) return;
      send_length(p, (len == MAX_PATTERN_LENGTH) ? $urandom_range(64, 127) : len);
   endtask

   // text with copies of stored patterns dropped in, some with a spoiled last byte
   task automatic text_run(int unsigned n);
      logic [7:0]  planted [$];
      int unsigned sent, p, len;
      sent = 0;
      while (sent < n || planted.size() != 0) begin
         if (planted.size() == 0 && $urandom_range(0, 3) == 0) begin
            p = $urandom_range(0, PATTERN_COUNT - 1);
            len = match_sb.pat_len[p];
            for (int k = 0; k < len; k++) planted = {planted, match_sb.pat_mem[p][k]};
            if (len > 1 && $urandom_range(0, 3) == 0) planted[len-1] = pick_byte();
         end
         if (planted.size() != 0) send_text(planted.pop_front());
         else send_text(pick_byte());
         sent++;
      end
   endtask

   task automatic noise_item();
      int unsigned p, wp;
      p = $urandom_range(0, PATTERN_COUNT - 1);
      wp = match_sb.written_prefix(p);
      case ($urandom_range(0, 3))
         0: send_load(p, $urandom_range(0, 63), $urandom_range(0, 255));
         1: send_length(p, 0);
         default: begin
            // only lengths whose bytes are all loaded
            if (wp == MAX_PATTERN_LENGTH && $urandom_range(0, 1))
               send_length(p, $urandom_range(64, 127));
            else send_length(p, $urandom_range(0, wp));
         end
      endcase
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (match_sb.expected_matches.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return MAX_PATTERN_LENGTH;
      if (r < 12) return $urandom_range(13, 63);
      if (r < 35) return $urandom_range(5, 12);
      return $urandom_range(1, 4);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) match_sb.check_match(rsp_chan.data);
   end

   initial begin : rsp_side
      int hold_left, mode, mode_left;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_wanted) begin
            long_stall_wanted = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (mode_left % 3 != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int          choice;
      logic [7:0]  flood_byte;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: nothing enabled yet, then two patterns ending on one byte
      send_text(8'h00);
      send_text(8'hff);
      send_load(0, 0, "a");
      send_load(0, 1, "b");
      send_length(0, 2);
      send_load(15, 0, "b");
      send_length(15, 1);
      send_new_text();
      send_text("a");
      send_text("b");
      send_text("b");
      send_length(0, 0);
      send_text("a");
      send_text("b");
      send_load(15, 63, 8'hff);
      send_load(7, 32, 8'h55);
      send_new_text();
      send_text("b");
      send_text("a");
      // rewrite a byte already passed by the text: flags get rebuilt
      send_load(0, 1, "c");
      send_length(0, 2);
      send_text("a");
      send_text("c");

      // full-length pattern with an oversized length, then planted copies
      program_pattern($urandom_range(0, PATTERN_COUNT - 1), MAX_PATTERN_LENGTH);
      send_new_text();
      text_run(80);

      // every pattern hits on one byte; long receiver hold backs up the input
      flood_byte = pick_byte();
      for (int p = 0; p < PATTERN_COUNT; p++) send_load(p, 0, flood_byte);
      for (int p = 0; p < PATTERN_COUNT; p++) send_length(p, 1);
      long_stall_wanted = 1'b1;
      repeat (20) send_text(flood_byte);
      hold_until_drained();

      while (match_sb.requests < ITEM_TARGET) begin
         choice = $urandom_range(0, 99);
         if (choice < 28) program_pattern($urandom_range(0, PATTERN_COUNT - 1), pick_length());
         else if (choice < 74) text_run($urandom_range(4, 40));
         else if (choice < 80) send_new_text();
         else if (choice < 95) noise_item();
         else hold_until_drained();
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d text bytes, %0d match beats checked",
               match_sb.requests, match_sb.text_bytes, match_sb.checked);
      $display("up to %0d matches on one byte, long receiver hold and full drains included",
               match_sb.widest_run);
      if (match_sb.errors == 0 && match_sb.expected_matches.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

@@ files.f @@
rtl/mpem_pkg.sv
rtl/mpem_stream_if.sv
rtl/mpem_cell.sv
rtl/mpem_emit.sv
rtl/multi_pattern_exact_matcher_unit.sv
dv/multi_pattern_exact_matcher_unit_test.sv
